[sv/utf8_to_utf16_decoder_assert.svh]
// assertion macros for the utf-8 to utf-16 decoder
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

// checked only while out of reset
`define U2U_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("u2u assertion failed");

// checked at every edge, reset included
`define U2U_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("u2u assertion failed");

`endif

[sv/u2u_pkg.sv]
`default_nettype none

package u2u_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [15:0] ReplacementChar = 16'hFFFD;
  localparam logic [20:0] SupplementBase  = 21'h10000;
  localparam logic [15:0] HighSurrogate   = 16'hD800;
  localparam logic [15:0] LowSurrogate    = 16'hDC00;

  // one decoded byte worth of output, one or two code units
  typedef struct packed {
    logic [15:0] unit0;
    logic        valid0;
    logic [15:0] unit1;
    logic        two;
    logic        last;
  } cmd_t;

endpackage

`default_nettype wire

[sv/u2u_front.sv]
`default_nettype none

module u2u_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_string_i,
  input  wire logic          q_full_i,
  output      logic          q_push_o,
  output      u2u_pkg::cmd_t q_cmd_o
);

  logic [1:0]  pend_q, pend_d;
  logic [20:0] cp_q, cp_d;

  logic        accept;
  logic        is_cont;
  logic [20:0] cp_ext;
  logic [20:0] cp_off;
  logic [1:0]  cnt;
  logic [15:0] unit_a, unit_b;
  logic        valid_a;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_cont    = (data_byte_i[7:6] == 2'b10);
  assign cp_ext     = {cp_q[14:0], data_byte_i[5:0]};
  assign cp_off     = cp_ext - u2u_pkg::SupplementBase;

  always_comb begin
    pend_d  = pend_q;
    cp_d    = cp_q;
    cnt     = 2'd0;
    unit_a  = '0;
    unit_b  = '0;
    valid_a = 1'b1;

    if ((pend_q != 2'd0) && is_cont) begin
      pend_d = pend_q - 2'd1;
      if (pend_d == 2'd0) begin
        cp_d = '0;
        if (cp_ext[20:16] == 5'd0) begin
          unit_a = cp_ext[15:0];
          cnt    = 2'd1;
        end else begin
          unit_a = u2u_pkg::HighSurrogate + {5'd0, cp_off[20:10]};
          unit_b = u2u_pkg::LowSurrogate + {6'd0, cp_off[9:0]};
          cnt    = 2'd2;
        end
      end else begin
        cp_d = cp_ext;
      end
    end else begin
      // interrupted sequence
      if (pend_q != 2'd0) begin
        unit_a = u2u_pkg::ReplacementChar;
        cnt    = 2'd1;
        pend_d = 2'd0;
        cp_d   = '0;
      end
      // new lead byte
      priority if (data_byte_i[7] == 1'b0) begin
        if (cnt == 2'd0) begin
          unit_a = {8'd0, data_byte_i};
        end else begin
          unit_b = {8'd0, data_byte_i};
        end
        cnt = cnt + 2'd1;
      end else if (data_byte_i[7:5] == 3'b110) begin
        cp_d   = {16'd0, data_byte_i[4:0]};
        pend_d = 2'd1;
      end else if (data_byte_i[7:4] == 4'b1110) begin
        cp_d   = {17'd0, data_byte_i[3:0]};
        pend_d = 2'd2;
      end else if (data_byte_i[7:3] == 5'b11110) begin
        cp_d   = {18'd0, data_byte_i[2:0]};
        pend_d = 2'd3;
      end else begin
        // stray continuation or invalid lead: dropped
      end
    end

    if (end_of_string_i) begin
      if (pend_d != 2'd0) begin
        if (cnt == 2'd0) begin
          unit_a = u2u_pkg::ReplacementChar;
        end else begin
          unit_b = u2u_pkg::ReplacementChar;
        end
        cnt = cnt + 2'd1;
      end
      pend_d = 2'd0;
      cp_d   = '0;
      if (cnt == 2'd0) begin
        unit_a  = '0;
        valid_a = 1'b0;
        cnt     = 2'd1;
      end
    end
  end

  assign q_push_o       = accept && (cnt != 2'd0);
  assign q_cmd_o.unit0  = unit_a;
  assign q_cmd_o.valid0 = valid_a;
  assign q_cmd_o.unit1  = unit_b;
  assign q_cmd_o.two    = (cnt == 2'd2);
  assign q_cmd_o.last   = end_of_string_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cp_q   <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      cp_q   <= cp_d;
    end
  end

endmodule

`default_nettype wire

[sv/u2u_queue.sv]
`default_nettype none

module u2u_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire u2u_pkg::cmd_t cmd_i,
  output      logic          full_o,
  output      logic          valid_o,
  output      u2u_pkg::cmd_t head_o,
  input  wire logic          pop_i
);

  u2u_pkg::cmd_t                       mem_q [u2u_pkg::QueueDepth];
  logic [u2u_pkg::QueuePtrW-1:0]       wr_q, rd_q;
  logic [u2u_pkg::QueueCntW-1:0]       cnt_q;
  logic                                do_push, do_pop;

  assign full_o  = (cnt_q == u2u_pkg::QueueCntW'(u2u_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == u2u_pkg::QueuePtrW'(u2u_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == u2u_pkg::QueuePtrW'(u2u_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/u2u_back.sv]
`default_nettype none

module u2u_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  wire u2u_pkg::cmd_t q_head_i,
  output      logic          q_pop_o,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      logic [15:0]   code_unit_o,
  output      logic          unit_valid_o,
  output      logic          last_unit_o
);

  logic        sel_q;
  logic        out_valid_q;
  logic [15:0] unit_q;
  logic        uvalid_q;
  logic        last_q;
  logic        load;

  assign load    = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = load && (sel_q || !q_head_i.two);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        sel_q       <= !sel_q && q_head_i.two;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sel_q) begin
        unit_q   <= q_head_i.unit1;
        uvalid_q <= 1'b1;
        last_q   <= q_head_i.last;
      end else begin
        unit_q   <= q_head_i.unit0;
        uvalid_q <= q_head_i.valid0;
        last_q   <= q_head_i.last && !q_head_i.two;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_unit_o  = unit_q;
  assign unit_valid_o = uvalid_q;
  assign last_unit_o  = last_q;

endmodule

`default_nettype wire

[sv/utf8_to_utf16_decoder.sv]
// channel   dir  tdata              tuser        tlast
// s_axis    in   [7:0] data_byte    -            end_of_string
// m_axis    out  [15:0] code_unit   unit_valid   last_unit
//
// one input byte per cycle while the queue is not full; each output unit is held in the output register until taken
// a byte that yields a surrogate pair or a replacement plus a unit is sent as two output units from one queue entry
// a byte goes from accept through a two-entry queue and then the output register to the first unit
// reset clears decode state, the queue pointers and count, and the output valid flag
// output stalls fill the queue, after which s_axis_tready_o drops
`default_nettype none

module utf8_to_utf16_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [15:0] m_axis_tdata_o,   // [15:0] code_unit
  output      logic        m_axis_tuser_o,   // [0] unit_valid
  output      logic        m_axis_tlast_o
);

  logic          q_push, q_full, q_valid, q_pop;
  u2u_pkg::cmd_t q_cmd, q_head;

  u2u_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .data_byte_i     (s_axis_tdata_i),
    .end_of_string_i (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_cmd)
  );

  u2u_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head),
    .pop_i   (q_pop)
  );

  u2u_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (q_head),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .code_unit_o  (m_axis_tdata_o),
    .unit_valid_o (m_axis_tuser_o),
    .last_unit_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[sv/u2u_checker.sv]
`default_nettype none
`include "utf8_to_utf16_decoder_assert.svh"

module u2u_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [7:0]  s_axis_tdata_i,
  input wire logic        s_axis_tlast_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o,
  input wire logic        m_axis_tlast_o
);

  logic in_txn;
  assign in_txn = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i != 8'hFF || s_axis_tlast_i);

  `U2U_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid_o)
  `U2U_ASSERT(a_hold_on_stall, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  `U2U_ASSERT(a_marker_is_last, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tlast_o && (m_axis_tdata_o == 16'h0000))
  `U2U_ASSERT(a_eos_yields_output, clk_i, rst_ni, in_txn && s_axis_tlast_i |=> ##1 m_axis_tvalid_o)

endmodule

bind utf8_to_utf16_decoder u2u_checker u_u2u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
